[rtl/icm_pkg.sv]
// Shared types and constants for the inertial cursor motion engine.
package icm_pkg;

  // Fixed-point fraction bits: one count is 2**FRAC_W velocity units.
  localparam int FRAC_W = 8;
  localparam int REM_W = FRAC_W + 1;
  localparam int MOVE_W = 16;
  localparam int UNIT_W = 16;
  localparam int GAIN_W = 16;
  localparam int LIM_W = 23;
  localparam int SCALED_W = LIM_W + 1;
  localparam int PROD_W = 32;
  localparam int IDX_W = 3;
  localparam int CFG_DATA_W = LIM_W;
  localparam int DATA_W = 48;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [IDX_W-1:0] {
    REG_ENABLED,
    REG_GAIN_X,
    REG_GAIN_Y,
    REG_LIMIT_X,
    REG_LIMIT_Y,
    REG_DRAG_X,
    REG_DRAG_Y
  } reg_idx_t;

  // Classification of an accepted request.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ZERO,
    KIND_MOVE,
    KIND_TICK
  } kind_t;

  // What the emit stage does with an item.
  typedef enum logic [1:0] {
    OP_PASS,
    OP_MOVE,
    OP_TICK
  } op_t;

  // Configuration as seen by the datapath; limits are already capped.
  typedef struct packed {
    logic             enabled;
    logic [GAIN_W-1:0] gain_x;
    logic [GAIN_W-1:0] gain_y;
    logic [LIM_W-1:0]  lim_x;
    logic [LIM_W-1:0]  lim_y;
    logic [LIM_W-1:0]  drag_x;
    logic [LIM_W-1:0]  drag_y;
  } cfg_t;

  // Queue entry between the front end and the back end.
  typedef struct packed {
    kind_t               kind;
    logic [MOVE_W-1:0]   move_x;
    logic [MOVE_W-1:0]   move_y;
    logic [UNIT_W-1:0]   unit;
    logic [SCALED_W-1:0] scaled_x;
    logic [SCALED_W-1:0] scaled_y;
  } item_t;

endpackage

[rtl/icm_front.sv]
// Front end: accepts requests, classifies them and scales the deltas by the gains.
module icm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  icm_pkg::cfg_t                    cfg,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: move_x [15:0], move_y [31:16], unit [47:32]
  input  logic [icm_pkg::DATA_W-1:0]       s_tdata,
  // s_tuser: action [0], absolute [1]
  input  logic [1:0]                       s_tuser,
  output logic                             push_valid,
  input  logic                             push_ready,
  output icm_pkg::item_t                   push_item
);

  logic                            action;
  logic                            absolute;
  logic [icm_pkg::MOVE_W-1:0]      mx;
  logic [icm_pkg::MOVE_W-1:0]      my;
  logic [icm_pkg::UNIT_W-1:0]      unit;
  icm_pkg::kind_t                  kind_in;
  logic [icm_pkg::MOVE_W:0]        mag_x;
  logic [icm_pkg::MOVE_W:0]        mag_y;
  logic [icm_pkg::PROD_W-1:0]      prod_x_next;
  logic [icm_pkg::PROD_W-1:0]      prod_y_next;

  logic                            f_valid;
  icm_pkg::kind_t                  f_kind;
  logic                            f_neg_x;
  logic                            f_neg_y;
  logic [icm_pkg::PROD_W-1:0]      f_prod_x;
  logic [icm_pkg::PROD_W-1:0]      f_prod_y;
  logic [icm_pkg::MOVE_W-1:0]      f_move_x;
  logic [icm_pkg::MOVE_W-1:0]      f_move_y;
  logic [icm_pkg::UNIT_W-1:0]      f_unit;

  logic [icm_pkg::LIM_W-1:0]       sat_x;
  logic [icm_pkg::LIM_W-1:0]       sat_y;

  // Unpack the request fields.
  assign action   = s_tuser[0];
  assign absolute = s_tuser[1];
  assign mx       = s_tdata[15:0];
  assign my       = s_tdata[31:16];
  assign unit     = s_tdata[47:32];

  // Classify the request.
  always_comb begin
    if (action) begin
      kind_in = icm_pkg::KIND_TICK;
    end else if (!cfg.enabled || absolute) begin
      kind_in = icm_pkg::KIND_PASS;
    end else if (mx == '0 && my == '0) begin
      kind_in = icm_pkg::KIND_ZERO;
    end else begin
      kind_in = icm_pkg::KIND_MOVE;
    end
  end

  // Magnitude of each delta times its gain; the sign is kept aside.
  assign mag_x = mx[15] ? (~{mx[15], mx} + 17'd1) : {1'b0, mx};
  assign mag_y = my[15] ? (~{my[15], my} + 17'd1) : {1'b0, my};
  assign prod_x_next = {15'd0, mag_x} * {16'd0, cfg.gain_x};
  assign prod_y_next = {15'd0, mag_y} * {16'd0, cfg.gain_y};

  // One-deep holding stage; it advances when the queue takes its entry.
  assign s_tready   = !f_valid || push_ready;
  assign push_valid = f_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      f_valid <= 1'b1;
    end else if (push_ready) begin
      f_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      f_kind   <= kind_in;
      f_neg_x  <= mx[15];
      f_neg_y  <= my[15];
      f_prod_x <= prod_x_next;
      f_prod_y <= prod_y_next;
      f_move_x <= mx;
      f_move_y <= my;
      f_unit   <= unit;
    end
  end

  // Saturate the scaled deltas at the axis limits and restore the sign.
  assign sat_x = (f_prod_x > {9'd0, cfg.lim_x}) ? cfg.lim_x : f_prod_x[22:0];
  assign sat_y = (f_prod_y > {9'd0, cfg.lim_y}) ? cfg.lim_y : f_prod_y[22:0];

  always_comb begin
    push_item.kind     = f_kind;
    push_item.move_x   = f_move_x;
    push_item.move_y   = f_move_y;
    push_item.unit     = f_unit;
    push_item.scaled_x = f_neg_x ? (24'd0 - {1'b0, sat_x}) : {1'b0, sat_x};
    push_item.scaled_y = f_neg_y ? (24'd0 - {1'b0, sat_y}) : {1'b0, sat_y};
  end

endmodule

[rtl/icm_queue.sv]
// Short request queue between the front end and the back end.
module icm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  icm_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output icm_pkg::item_t pop_item
);

  icm_pkg::item_t                entries [icm_pkg::QUEUE_DEPTH];
  logic [icm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [icm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [icm_pkg::QCNT_W-1:0]    count;
  logic                          push;
  logic                          pop;

  assign push_ready = (count != icm_pkg::QCNT_W'(icm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == icm_pkg::QPTR_W'(icm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == icm_pkg::QPTR_W'(icm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[rtl/icm_back.sv]
// Back end: velocity update, residual accumulation, count emission and output register.
module icm_back #(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  icm_pkg::cfg_t               cfg,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  icm_pkg::item_t              pop_item,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // m_tdata: emit_x [15:0], emit_y [31:16], emit_unit [47:32]
  output logic [icm_pkg::DATA_W-1:0]  m_tdata,
  // m_tuser: handled [0]
  output logic [0:0]                  m_tuser
);

  localparam int SW = SPEED_WIDTH;
  localparam int AW = ((SW > icm_pkg::SCALED_W) ? SW : icm_pkg::SCALED_W) + 2;
  localparam int FW = icm_pkg::FRAC_W;
  localparam int MW = icm_pkg::MOVE_W;

  // Saturating add at plus or minus the limit.
  function automatic logic signed [AW-1:0] clamp_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] b,
                                                     input logic [icm_pkg::LIM_W-1:0] lim);
    logic signed [AW-1:0] s;
    logic signed [AW-1:0] l;
    s = a + b;
    l = $signed(AW'(lim));
    if (s > l) begin
      return l;
    end else if (s < -l) begin
      return -l;
    end
    return s;
  endfunction

  // Pull a velocity toward zero by the drag, stopping at zero.
  function automatic logic signed [AW-1:0] drag_to_zero(input logic signed [AW-1:0] v,
                                                        input logic [icm_pkg::LIM_W-1:0] d);
    logic signed [AW-1:0] dd;
    dd = $signed(AW'(d));
    if (v > dd) begin
      return v - dd;
    end else if (v < -dd) begin
      return v + dd;
    end
    return '0;
  endfunction

  logic signed [SW-1:0]             speed_x;
  logic signed [SW-1:0]             speed_y;
  logic signed [icm_pkg::REM_W-1:0] rem_x;
  logic signed [icm_pkg::REM_W-1:0] rem_y;
  logic                             template_valid;
  logic [icm_pkg::UNIT_W-1:0]       template_unit;

  logic                             s2_valid;
  icm_pkg::op_t                     s2_op;
  logic signed [SW-1:0]             s2_src_x;
  logic signed [SW-1:0]             s2_src_y;
  logic [MW-1:0]                    s2_move_x;
  logic [MW-1:0]                    s2_move_y;
  logic [icm_pkg::UNIT_W-1:0]       s2_unit;

  logic                             s1_go;
  logic                             s2_go;
  logic                             tick_live;
  logic signed [AW-1:0]             speed_x_mv;
  logic signed [AW-1:0]             speed_y_mv;
  logic signed [AW-1:0]             speed_x_dr;
  logic signed [AW-1:0]             speed_y_dr;
  logic signed [AW-1:0]             acc_x;
  logic signed [AW-1:0]             acc_y;
  logic                             neg_x;
  logic                             neg_y;
  logic [MW-1:0]                    q_x;
  logic [MW-1:0]                    q_y;
  logic                             handled_next;
  logic [MW-1:0]                    emit_x_next;
  logic [MW-1:0]                    emit_y_next;

  // Stage handshakes: stage two moves when the output register is free.
  assign s2_go     = s2_valid && (!m_tvalid || m_tready);
  assign pop_ready = !s2_valid || s2_go;
  assign s1_go     = pop_valid && pop_ready;
  assign tick_live = cfg.enabled && template_valid;

  // Velocity update for motion, friction for ticks.
  assign speed_x_mv = clamp_add(AW'(speed_x), AW'($signed(pop_item.scaled_x)), cfg.lim_x);
  assign speed_y_mv = clamp_add(AW'(speed_y), AW'($signed(pop_item.scaled_y)), cfg.lim_y);
  assign speed_x_dr = drag_to_zero(AW'(speed_x), cfg.drag_x);
  assign speed_y_dr = drag_to_zero(AW'(speed_y), cfg.drag_y);

  // Stage one: velocity and template state, and the velocity to emit from.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_x        <= '0;
      speed_y        <= '0;
      template_valid <= 1'b0;
      template_unit  <= '0;
      s2_valid       <= 1'b0;
    end else begin
      if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s1_go) begin
        case (pop_item.kind)
          icm_pkg::KIND_MOVE: begin
            speed_x        <= speed_x_mv[SW-1:0];
            speed_y        <= speed_y_mv[SW-1:0];
            template_valid <= 1'b1;
            template_unit  <= pop_item.unit;
          end
          icm_pkg::KIND_ZERO: begin
            template_valid <= 1'b1;
            template_unit  <= pop_item.unit;
          end
          icm_pkg::KIND_TICK: begin
            if (tick_live) begin
              speed_x <= speed_x_dr[SW-1:0];
              speed_y <= speed_y_dr[SW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Stage one payload; a tick emits from the velocity before friction.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      case (pop_item.kind)
        icm_pkg::KIND_MOVE: begin
          s2_move_x <= pop_item.move_x;
          s2_move_y <= pop_item.move_y;
          s2_unit   <= pop_item.unit;
          s2_src_x  <= speed_x_mv[SW-1:0];
          s2_src_y  <= speed_y_mv[SW-1:0];
          s2_op     <= icm_pkg::OP_MOVE;
        end
        icm_pkg::KIND_TICK: begin
          s2_move_x <= '0;
          s2_move_y <= '0;
          s2_unit   <= template_unit;
          s2_src_x  <= speed_x;
          s2_src_y  <= speed_y;
          s2_op     <= tick_live ? icm_pkg::OP_TICK : icm_pkg::OP_PASS;
        end
        default: begin
          s2_move_x <= pop_item.move_x;
          s2_move_y <= pop_item.move_y;
          s2_unit   <= pop_item.unit;
          s2_src_x  <= speed_x_mv[SW-1:0];
          s2_src_y  <= speed_y_mv[SW-1:0];
          s2_op     <= icm_pkg::OP_PASS;
        end
      endcase
    end
  end

  // Stage two: residual accumulation and truncation toward zero.
  assign acc_x = clamp_add(AW'(rem_x), AW'(s2_src_x), cfg.lim_x);
  assign acc_y = clamp_add(AW'(rem_y), AW'(s2_src_y), cfg.lim_y);
  assign neg_x = acc_x[AW-1] && (acc_x[FW-1:0] != '0);
  assign neg_y = acc_y[AW-1] && (acc_y[FW-1:0] != '0);
  assign q_x   = acc_x[FW+MW-1:FW] + MW'(neg_x);
  assign q_y   = acc_y[FW+MW-1:FW] + MW'(neg_y);

  // Result selection.
  always_comb begin
    case (s2_op)
      icm_pkg::OP_MOVE: begin
        handled_next = 1'b1;
        emit_x_next  = q_x;
        emit_y_next  = q_y;
      end
      icm_pkg::OP_TICK: begin
        handled_next = (q_x != '0) || (q_y != '0);
        emit_x_next  = q_x;
        emit_y_next  = q_y;
      end
      default: begin
        handled_next = 1'b0;
        emit_x_next  = s2_move_x;
        emit_y_next  = s2_move_y;
      end
    endcase
  end

  // Residual state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_x    <= '0;
      rem_y    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s2_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (s2_go && (s2_op != icm_pkg::OP_PASS)) begin
        rem_x <= {neg_x, acc_x[FW-1:0]};
        rem_y <= {neg_y, acc_y[FW-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      m_tdata <= {s2_unit, emit_y_next, emit_x_next};
      m_tuser <= handled_next;
    end
  end

`ifndef SYNTH
  // A residual never reaches a whole count in the negative direction.
  assert property (@(posedge clk) disable iff (rst)
    (rem_x != {1'b1, {FW{1'b0}}}) && (rem_y != {1'b1, {FW{1'b0}}}))
    else $error("residual magnitude reached a whole count");

  // Velocities stay within the symmetric range.
  assert property (@(posedge clk) disable iff (rst)
    (speed_x != {1'b1, {(SW-1){1'b0}}}) && (speed_y != {1'b1, {(SW-1){1'b0}}}))
    else $error("velocity left the symmetric range");

  // A passed-through item leaves as unhandled.
  assert property (@(posedge clk) disable iff (rst)
    s2_go && (s2_op == icm_pkg::OP_PASS) |=> m_tvalid && !m_tuser[0])
    else $error("passthrough item marked handled");
`endif

endmodule

[rtl/inertial_cursor_motion.sv]
// Top level of the inertial cursor motion engine: configuration registers and the pipeline.
//
//   Channel   Signals                                  Direction  Request content
//   s         s_tvalid s_tready s_tdata s_tuser        in         motion packet or friction tick
//   m         m_tvalid m_tready m_tdata m_tuser        out        one result per request
//   cfg       cfg_valid cfg_ready cfg_index cfg_data   in         register write, always ready
//
// One request per clock is sustained while the output takes results; the velocity and residual loops each close
// within one back-end stage. On an empty pipeline a result passes through the holding stage,
// the queue, the velocity stage and then the output register after the request is accepted.
// Reset is synchronous and needs no clearing pass; all state is ready the next clock.
// A stalled output fills the back end, then the queue, then drops s_tready.
module inertial_cursor_motion #(
  parameter int SPEED_WIDTH = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: move_x [15:0], move_y [31:16], unit [47:32]
  input  logic [icm_pkg::DATA_W-1:0]        s_tdata,
  // s_tuser: action [0], absolute [1]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: emit_x [15:0], emit_y [31:16], emit_unit [47:32]
  output logic [icm_pkg::DATA_W-1:0]        m_tdata,
  // m_tuser: handled [0]
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [icm_pkg::IDX_W-1:0]         cfg_index,
  input  logic [icm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam logic [31:0] SPEED_MAX = (32'd1 << (SPEED_WIDTH - 1)) - 32'd1;

  logic                          enabled;
  logic [icm_pkg::GAIN_W-1:0]    gain_x;
  logic [icm_pkg::GAIN_W-1:0]    gain_y;
  logic [icm_pkg::LIM_W-1:0]     limit_x;
  logic [icm_pkg::LIM_W-1:0]     limit_y;
  logic [icm_pkg::LIM_W-1:0]     drag_x;
  logic [icm_pkg::LIM_W-1:0]     drag_y;

  icm_pkg::cfg_t                 cfg;
  logic                          push_valid;
  logic                          push_ready;
  icm_pkg::item_t                push_item;
  logic                          pop_valid;
  logic                          pop_ready;
  icm_pkg::item_t                pop_item;

  assign cfg_ready = 1'b1;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      gain_x  <= 16'd256;
      gain_y  <= 16'd256;
      limit_x <= 23'h7FFFFF;
      limit_y <= 23'h7FFFFF;
      drag_x  <= '0;
      drag_y  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        icm_pkg::REG_ENABLED: enabled <= cfg_data[0];
        icm_pkg::REG_GAIN_X:  gain_x  <= cfg_data[15:0];
        icm_pkg::REG_GAIN_Y:  gain_y  <= cfg_data[15:0];
        icm_pkg::REG_LIMIT_X: limit_x <= cfg_data;
        icm_pkg::REG_LIMIT_Y: limit_y <= cfg_data;
        icm_pkg::REG_DRAG_X:  drag_x  <= cfg_data;
        icm_pkg::REG_DRAG_Y:  drag_y  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Limits are capped at the largest velocity the speed registers hold.
  always_comb begin
    cfg.enabled = enabled;
    cfg.gain_x  = gain_x;
    cfg.gain_y  = gain_y;
    cfg.lim_x   = ({9'd0, limit_x} > SPEED_MAX) ? SPEED_MAX[22:0] : limit_x;
    cfg.lim_y   = ({9'd0, limit_y} > SPEED_MAX) ? SPEED_MAX[22:0] : limit_y;
    cfg.drag_x  = drag_x;
    cfg.drag_y  = drag_y;
  end

  icm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  icm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  icm_back #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
